// File: src/nmea_pkg.sv
// Package for the NMEA RMC sentence parser: phase codes, character constants and helpers.
// No dependencies.
`default_nettype none
package nmea_pkg;

    typedef enum logic [4:0] {
        PH_IDLE, PH_TALK, PH_UTC, PH_STAT, PH_LATD, PH_LATM, PH_LATH, PH_LOND,
        PH_LONM, PH_LONH, PH_SPD, PH_TRK, PH_DATE, PH_MVAR, PH_MDIR, PH_STAR, PH_CSUM
    } phase_t;

    localparam int UTC_FAIL_COUNT_DEF     = 10;
    localparam int MINUTES_FAIL_COUNT_DEF = 9;
    localparam int NUMBER_FAIL_COUNT_DEF  = 10;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_W      = 8'h57;

    localparam logic [23:0] SAT24 = 24'hFFFFFF;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // Decimal accumulate; scale_sel 1: 1/10000 units (4 frac digits), 0: 1/100 (2).
    function automatic logic [27:0] num_char(input logic [23:0] acc, input logic [7:0] c,
                                             input logic [3:0] dt, input logic scale_sel);
        logic [2:0]  cnt;
        logic [3:0]  d;
        logic [35:0] v;
        logic [13:0] place;
        logic [2:0]  fracmax;
        logic [3:0]  dt_n;
        logic [23:0] acc_n;
        cnt     = dt[2:0];
        d       = c[3:0];
        fracmax = scale_sel ? 3'd4 : 3'd2;
        dt_n    = dt;
        acc_n   = acc;
        v       = '0;
        if (cnt == 3'd7) begin
            acc_n = acc;
        end else if (c == CH_DOT) begin
            dt_n = dt[3] ? 4'hF : 4'h8;
        end else if (!dt[3]) begin
            v = {12'd0, acc} * 36'd10 + 36'(d) * (scale_sel ? 36'd10000 : 36'd100);
            acc_n = (v > 36'(SAT24)) ? SAT24 : v[23:0];
        end else if (cnt < fracmax) begin
            case ({scale_sel, cnt[1:0]})
                3'b100:  place = 14'd1000;
                3'b101:  place = 14'd100;
                3'b110:  place = 14'd10;
                3'b111:  place = 14'd1;
                3'b000:  place = 14'd10;
                default: place = 14'd1;
            endcase
            v = {12'd0, acc} + 36'(d) * 36'(place);
            acc_n = (v > 36'(SAT24)) ? SAT24 : v[23:0];
            dt_n = {1'b1, cnt + 3'd1};
        end
        return {dt_n, acc_n};
    endfunction

endpackage
`default_nettype wire

// File: src/nmea_rmc_sentence_parser_top.sv
// NMEA RMC sentence parser top level: per-byte parse state machine and result register.
// Depends on nmea_pkg.
//
// channel | direction | payload
// s_      | in        | s_rx_byte
// m_      | out       | utc, lat, lon, hemispheres, speed, track
//
// One byte per cycle; the parse state updates at each accepted transaction.
// A result with a matching checksum appears in the output register the cycle after the LF is accepted.
// Input stalls only while a result is held and m_ready is low.
// Reset (aresetn low, synchronous) returns the parser to idle.
`default_nettype none
module nmea_rmc_sentence_parser_top #(
    parameter int UTC_FAIL_COUNT     = nmea_pkg::UTC_FAIL_COUNT_DEF,
    parameter int MINUTES_FAIL_COUNT = nmea_pkg::MINUTES_FAIL_COUNT_DEF,
    parameter int NUMBER_FAIL_COUNT  = nmea_pkg::NUMBER_FAIL_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [6:0]       m_utc_hours,
    output logic [6:0]       m_utc_minutes,
    output logic [6:0]       m_utc_seconds,
    output logic [6:0]       m_lat_degrees,
    output logic [23:0]      m_lat_minutes_fx,
    output logic             m_lat_south,
    output logic [9:0]       m_lon_degrees,
    output logic [23:0]      m_lon_minutes_fx,
    output logic             m_lon_west,
    output logic [23:0]      m_speed_centi,
    output logic [23:0]      m_track_centi
);
    import nmea_pkg::*;

    localparam logic [3:0] UTC_FAIL = 4'(UTC_FAIL_COUNT);
    localparam logic [3:0] MIN_FAIL = 4'(MINUTES_FAIL_COUNT);
    localparam logic [3:0] NUM_FAIL = 4'(NUMBER_FAIL_COUNT);

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        comma_reg, comma_next;
    logic [1:0]  le_reg, le_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  chk_reg, chk_next;
    logic [23:0] utc_reg, utc_next;
    logic [31:0] lat_reg, lat_next;
    logic [34:0] lon_reg, lon_next;
    logic [23:0] spd_reg, spd_next;
    logic [23:0] trk_reg, trk_next;
    logic [3:0]  dt_reg, dt_next;
    logic        emit;

    logic [3:0]  cnt_b;
    logic [27:0] nc;
    logic [4:0]  hx;
    logic        take;
    logic [3:0]  fail_n, minc;
    logic        dot_ok;
    logic [10:0] deg;
    logic [3:0]  d;

    logic        out_valid_reg;
    logic [6:0]  o_h_reg, o_m_reg, o_s_reg, o_latd_reg;
    logic [23:0] o_latm_reg, o_lonm_reg, o_spd_reg, o_trk_reg;
    logic        o_south_reg, o_west_reg;
    logic [9:0]  o_lond_reg;

    wire logic c_acc = s_valid && s_ready;
    wire logic [7:0] c = s_rx_byte;

    assign s_ready = !out_valid_reg || m_ready;

    always_comb begin
        phase_next = phase_reg; cnt_next = cnt_reg; comma_next = comma_reg;
        le_next = le_reg; xor_next = xor_reg; chk_next = chk_reg; utc_next = utc_reg;
        lat_next = lat_reg; lon_next = lon_reg; spd_next = spd_reg; trk_next = trk_reg;
        dt_next = dt_reg; emit = 1'b0; take = 1'b0;
        d = c[3:0];
        cnt_b = (cnt_reg < 4'd15) ? cnt_reg + 4'd1 : cnt_reg;
        nc = '0; deg = '0;
        fail_n = 4'd0; minc = 4'd0; dot_ok = 1'b0;
        hx = 5'h10;
        if (is_dig(c)) hx = {1'b0, d};
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            hx = {1'b0, c[3:0] + 4'd9};
        if (phase_reg >= PH_TALK && phase_reg <= PH_MDIR) xor_next = xor_reg ^ c;

        unique case (phase_reg)
            PH_UTC:  begin fail_n = UTC_FAIL; minc = 4'd6; end
            PH_LATM, PH_LONM: begin fail_n = MIN_FAIL; minc = 4'd2; dot_ok = 1'b1; end
            PH_SPD, PH_TRK: begin fail_n = NUM_FAIL; minc = 4'd1; dot_ok = 1'b1; end
            PH_DATE: minc = 4'd6;
            PH_MVAR: begin minc = 4'd1; dot_ok = 1'b1; end
            default: ;
        endcase

        unique case (phase_reg)
            PH_IDLE: begin
                cnt_next = '0; comma_next = 1'b0; le_next = '0; dt_next = '0;
                if (c == CH_DOLLAR) begin
                    xor_next = '0; chk_next = '0; phase_next = PH_TALK;
                end
            end
            PH_TALK: begin
                if (c == CH_STAR || c == CH_CR || c == CH_LF || c == CH_L) begin
                    phase_next = PH_IDLE; cnt_next = '0; comma_next = 1'b0;
                end else if (c == CH_COMMA) begin
                    comma_next = 1'b1;
                end else if (cnt_reg > 4'd5 || !is_alpha(c)) begin
                    phase_next = PH_IDLE; cnt_next = '0; comma_next = 1'b0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
                if (phase_next == PH_TALK && cnt_next == 4'd5 && comma_next) begin
                    phase_next = PH_UTC; cnt_next = '0; comma_next = 1'b0;
                    le_next = '0; dt_next = '0;
                end
            end
            PH_UTC, PH_LATM, PH_LONM, PH_SPD, PH_TRK, PH_DATE, PH_MVAR: begin
                if (is_dig(c) || (dot_ok && c == CH_DOT)) begin
                    cnt_next = cnt_b;
                    if (fail_n != 4'd0 && cnt_b >= fail_n) begin
                        phase_next = PH_IDLE; cnt_next = '0; comma_next = 1'b0;
                        le_next = '0; dt_next = '0;
                    end else begin
                        take = 1'b1;
                    end
                end else begin
                    phase_next = (c == CH_COMMA && cnt_reg >= minc)
                        ? phase_t'(phase_reg + 5'd1) : PH_IDLE;
                    cnt_next = '0; comma_next = 1'b0; le_next = '0; dt_next = '0;
                end
                if (take) begin
                    case (phase_reg)
                        PH_UTC: begin
                            case (cnt_b)
                                4'd1: utc_next[3:0]   = d;
                                4'd2: utc_next[7:4]   = d;
                                4'd3: utc_next[11:8]  = d;
                                4'd4: utc_next[15:12] = d;
                                4'd5: utc_next[19:16] = d;
                                4'd6: utc_next[23:20] = d;
                                default: ;
                            endcase
                        end
                        PH_LATM: begin
                            nc = num_char((cnt_b == 4'd1) ? 24'd0 : lat_reg[23:0], c,
                                          dt_reg, 1'b1);
                            lat_next[23:0] = nc[23:0]; dt_next = nc[27:24];
                        end
                        PH_LONM: begin
                            nc = num_char((cnt_b == 4'd1) ? 24'd0 : lon_reg[23:0], c,
                                          dt_reg, 1'b1);
                            lon_next[23:0] = nc[23:0]; dt_next = nc[27:24];
                        end
                        PH_SPD: begin
                            nc = num_char((cnt_b == 4'd1) ? 24'd0 : spd_reg, c, dt_reg, 1'b0);
                            spd_next = nc[23:0]; dt_next = nc[27:24];
                        end
                        PH_TRK: begin
                            nc = num_char((cnt_b == 4'd1) ? 24'd0 : trk_reg, c, dt_reg, 1'b0);
                            trk_next = nc[23:0]; dt_next = nc[27:24];
                        end
                        default: ;
                    endcase
                end
            end
            PH_STAT, PH_LATH, PH_LONH: begin
                if ((phase_reg == PH_STAT && c == CH_A) ||
                    (phase_reg == PH_LATH && (c == CH_N || c == CH_S)) ||
                    (phase_reg == PH_LONH && (c == CH_E || c == CH_W))) begin
                    cnt_next = cnt_b;
                    if (cnt_b > 4'd1) begin
                        phase_next = PH_IDLE; cnt_next = '0; comma_next = 1'b0;
                        le_next = '0; dt_next = '0;
                    end else if (phase_reg == PH_LATH) begin
                        lat_next[31] = (c == CH_S);
                    end else if (phase_reg == PH_LONH) begin
                        lon_next[34] = (c == CH_W);
                    end
                end else begin
                    phase_next = (c == CH_COMMA && cnt_reg == 4'd1)
                        ? phase_t'(phase_reg + 5'd1) : PH_IDLE;
                    cnt_next = '0; comma_next = 1'b0; le_next = '0; dt_next = '0;
                end
            end
            PH_LATD, PH_LOND: begin
                if (!is_dig(c)) begin
                    phase_next = PH_IDLE; cnt_next = '0; comma_next = 1'b0;
                    le_next = '0; dt_next = '0;
                end else begin
                    if (phase_reg == PH_LATD) begin
                        deg = (cnt_reg == 4'd0) ? 11'd0 : {4'd0, lat_reg[30:24]} * 11'd10;
                        deg = deg + 11'(d);
                        lat_next[30:24] = deg[6:0];
                    end else begin
                        deg = (cnt_reg == 4'd0) ? 11'd0 : 11'(lon_reg[33:24] * 10'd10);
                        deg = deg + 11'(d);
                        lon_next[33:24] = deg[9:0];
                    end
                    cnt_next = cnt_b;
                    if ((phase_reg == PH_LATD && cnt_b == 4'd2) ||
                        (phase_reg == PH_LOND && cnt_b == 4'd3)) begin
                        phase_next = phase_t'(phase_reg + 5'd1); cnt_next = '0;
                        comma_next = 1'b0; le_next = '0; dt_next = '0;
                    end
                end
            end
            PH_MDIR, PH_STAR: begin
                if ((phase_reg == PH_MDIR && (c == CH_E || c == CH_W)) ||
                    (phase_reg == PH_STAR && c == CH_STAR))
                    phase_next = phase_t'(phase_reg + 5'd1);
                else phase_next = PH_IDLE;
                cnt_next = '0; comma_next = 1'b0; le_next = '0; dt_next = '0;
            end
            PH_CSUM: begin
                if (!hx[4] && cnt_reg < 4'd2 && le_reg == 2'd0) begin
                    chk_next = {chk_reg[3:0], hx[3:0]};
                    cnt_next = cnt_reg + 4'd1;
                end else if (c == CH_CR && cnt_reg == 4'd2 && le_reg == 2'd0) begin
                    le_next = 2'd1;
                end else begin
                    if (c == CH_LF && cnt_reg == 4'd2 && le_reg == 2'd1)
                        emit = (chk_reg == xor_reg);
                    phase_next = PH_IDLE; cnt_next = '0; comma_next = 1'b0;
                    le_next = '0; dt_next = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE; cnt_next = '0; comma_next = 1'b0;
                le_next = '0; dt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; cnt_reg <= '0; comma_reg <= 1'b0; le_reg <= '0;
            xor_reg <= '0; chk_reg <= '0; utc_reg <= '0; lat_reg <= '0; lon_reg <= '0;
            spd_reg <= '0; trk_reg <= '0; dt_reg <= '0; out_valid_reg <= 1'b0;
        end else begin
            if (c_acc) begin
                phase_reg <= phase_next; cnt_reg <= cnt_next; comma_reg <= comma_next;
                le_reg <= le_next; xor_reg <= xor_next; chk_reg <= chk_next;
                utc_reg <= utc_next; lat_reg <= lat_next; lon_reg <= lon_next;
                spd_reg <= spd_next; trk_reg <= trk_next; dt_reg <= dt_next;
            end
            if (c_acc && emit) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_acc && emit) begin
            o_h_reg    <= 7'(utc_reg[3:0] * 7'd10) + 7'(utc_reg[7:4]);
            o_m_reg    <= 7'(utc_reg[11:8] * 7'd10) + 7'(utc_reg[15:12]);
            o_s_reg    <= 7'(utc_reg[19:16] * 7'd10) + 7'(utc_reg[23:20]);
            o_latd_reg <= lat_reg[30:24];
            o_latm_reg <= lat_reg[23:0];
            o_south_reg <= lat_reg[31];
            o_lond_reg <= lon_reg[33:24];
            o_lonm_reg <= lon_reg[23:0];
            o_west_reg <= lon_reg[34];
            o_spd_reg  <= spd_reg;
            o_trk_reg  <= trk_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_utc_hours = o_h_reg;
    assign m_utc_minutes = o_m_reg;
    assign m_utc_seconds = o_s_reg;
    assign m_lat_degrees = o_latd_reg;
    assign m_lat_minutes_fx = o_latm_reg;
    assign m_lat_south = o_south_reg;
    assign m_lon_degrees = o_lond_reg;
    assign m_lon_minutes_fx = o_lonm_reg;
    assign m_lon_west = o_west_reg;
    assign m_speed_centi = o_spd_reg;
    assign m_track_centi = o_trk_reg;
endmodule
`default_nettype wire

// File: src/nmea_checker.sv
// Port-level checker for the NMEA RMC parser, bound to the top level.
// Depends on nmea_rmc_sentence_parser_top ports only.
`default_nettype none
module nmea_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [6:0] m_utc_hours
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_utc_hours))
        else $error("result changed while stalled");
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");
    a_no_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result without transaction");
endmodule

bind nmea_rmc_sentence_parser_top nmea_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_utc_hours(m_utc_hours)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for nmea_rmc_sentence_parser_top: sends random and directed sentences.
// Depends on nmea_pkg and the parser RTL; predicts decoded results in a scoreboard class.
module testbench;
    import nmea_pkg::*;

    typedef struct packed {
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [6:0]  lat_deg;
        logic [23:0] lat_min;
        logic        south;
        logic [9:0]  lon_deg;
        logic [23:0] lon_min;
        logic        west;
        logic [23:0] speed;
        logic [23:0] track;
    } fix_t;

    class fix_scoreboard;
        fix_t        fix_q[$];
        int          mismatches;
        int          checked;
        phase_t      ph;
        bit [3:0]    cnt;
        bit          comma;
        bit [1:0]    le;
        bit [7:0]    xsum;
        bit [7:0]    rsum;
        bit [3:0]    utc[6];
        bit [6:0]    lat_deg;
        bit [23:0]   lat_min;
        bit          south;
        bit [9:0]    lon_deg;
        bit [23:0]   lon_min;
        bit          west;
        bit [23:0]   speed;
        bit [23:0]   track;
        bit [3:0]    dt;

        function new();
            mismatches = 0;
            checked = 0;
            goto_phase(PH_IDLE);
            xsum = 0;
            rsum = 0;
            foreach (utc[i]) utc[i] = 0;
            lat_deg = 0; lat_min = 0; south = 0;
            lon_deg = 0; lon_min = 0; west = 0;
            speed = 0; track = 0;
        endfunction

        function void goto_phase(phase_t p);
            ph = p; cnt = 0; comma = 0; le = 0; dt = 0;
        endfunction

        function void tick();
            if (cnt < 15) cnt++;
        endfunction

        function bit digit(bit [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit [23:0] accumulate(bit [23:0] acc, bit [7:0] c, int scale, int fracmax);
            int     n;
            int     place;
            longint v;
            n = dt[2:0];
            if (n == 7) return acc;
            if (c == ".") begin
                dt = dt[3] ? 4'hF : 4'h8;
                return acc;
            end
            if (!dt[3]) begin
                v = longint'(acc) * 10 + longint'(c - "0") * scale;
            end else begin
                if (n >= fracmax) return acc;
                place = scale;
                for (int i = 0; i <= n; i++) place /= 10;
                v = longint'(acc) + longint'(c - "0") * place;
                dt = {1'b1, 3'(n + 1)};
            end
            return v > 24'hFFFFFF ? 24'hFFFFFF : v[23:0];
        endfunction

        function bit take_char(bit [7:0] c, bit dot_ok, int fail, int minc, phase_t nxt);
            if (digit(c) || (dot_ok && c == ".")) begin
                tick();
                if (fail != 0 && cnt >= fail) begin
                    goto_phase(PH_IDLE);
                    return 0;
                end
                return 1;
            end
            if (c == ",") goto_phase(cnt >= minc ? nxt : PH_IDLE);
            else goto_phase(PH_IDLE);
            return 0;
        endfunction

        function bit take_letter(bit [7:0] c, bit ok, phase_t nxt);
            if (ok) begin
                tick();
                if (cnt > 1) begin
                    goto_phase(PH_IDLE);
                    return 0;
                end
                return 1;
            end
            goto_phase((c == "," && cnt == 1) ? nxt : PH_IDLE);
            return 0;
        endfunction

        function bit hex_digit(bit [7:0] c, output bit [3:0] h);
            h = 0;
            if (digit(c)) h = 4'(c - "0");
            else if (c >= "A" && c <= "F") h = 4'(c - "A" + 10);
            else if (c >= "a" && c <= "f") h = 4'(c - "a" + 10);
            else return 0;
            return 1;
        endfunction

        // advance the parser by one byte; push the fix when a sentence completes with a matching checksum
        function void note_byte(bit [7:0] c);
            int       m;
            bit [3:0] h;
            bit       ok;
            fix_t     f;
            if (ph >= PH_TALK && ph <= PH_MDIR) xsum ^= c;
            case (ph)
                PH_IDLE: begin
                    goto_phase(PH_IDLE);
                    if (c == "$") begin
                        xsum = 0; rsum = 0;
                        goto_phase(PH_TALK);
                    end
                end
                PH_TALK: begin
                    if (c == "*" || c == 8'h0D || c == 8'h0A || c == "L") goto_phase(PH_IDLE);
                    else if (c == ",") comma = 1;
                    else if (cnt > 5 || !((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")))
                        goto_phase(PH_IDLE);
                    else cnt++;
                    if (ph == PH_TALK && cnt == 5 && comma) goto_phase(PH_UTC);
                end
                PH_UTC: begin
                    if (take_char(c, 0, UTC_FAIL_COUNT_DEF, 6, PH_STAT) && cnt <= 6)
                        utc[cnt - 1] = 4'(c - "0");
                end
                PH_STAT: ok = take_letter(c, c == "A", PH_LATD);
                PH_LATD: begin
                    if (!digit(c)) begin
                        goto_phase(PH_IDLE);
                    end else begin
                        m = (cnt == 0) ? 0 : lat_deg * 10;
                        lat_deg = 7'(m + (c - "0"));
                        tick();
                        if (cnt == 2) goto_phase(PH_LATM);
                    end
                end
                PH_LATM: begin
                    if (take_char(c, 1, MINUTES_FAIL_COUNT_DEF, 2, PH_LATH))
                        lat_min = accumulate(cnt == 1 ? 24'd0 : lat_min, c, 10000, 4);
                end
                PH_LATH: if (take_letter(c, c == "N" || c == "S", PH_LOND)) south = (c == "S");
                PH_LOND: begin
                    if (!digit(c)) begin
                        goto_phase(PH_IDLE);
                    end else begin
                        m = (cnt == 0) ? 0 : lon_deg * 10;
                        lon_deg = 10'(m + (c - "0"));
                        tick();
                        if (cnt == 3) goto_phase(PH_LONM);
                    end
                end
                PH_LONM: begin
                    if (take_char(c, 1, MINUTES_FAIL_COUNT_DEF, 2, PH_LONH))
                        lon_min = accumulate(cnt == 1 ? 24'd0 : lon_min, c, 10000, 4);
                end
                PH_LONH: if (take_letter(c, c == "E" || c == "W", PH_SPD)) west = (c == "W");
                PH_SPD: begin
                    if (take_char(c, 1, NUMBER_FAIL_COUNT_DEF, 1, PH_TRK))
                        speed = accumulate(cnt == 1 ? 24'd0 : speed, c, 100, 2);
                end
                PH_TRK: begin
                    if (take_char(c, 1, NUMBER_FAIL_COUNT_DEF, 1, PH_DATE))
                        track = accumulate(cnt == 1 ? 24'd0 : track, c, 100, 2);
                end
                PH_DATE: ok = take_char(c, 0, 0, 6, PH_MVAR);
                PH_MVAR: ok = take_char(c, 1, 0, 1, PH_MDIR);
                PH_MDIR: goto_phase((c == "E" || c == "W") ? PH_STAR : PH_IDLE);
                PH_STAR: goto_phase(c == "*" ? PH_CSUM : PH_IDLE);
                PH_CSUM: begin
                    if (hex_digit(c, h) && cnt < 2 && le == 0) begin
                        rsum = {rsum[3:0], h};
                        cnt++;
                    end else if (c == 8'h0D && cnt == 2 && le == 0) begin
                        le = 1;
                    end else if (c == 8'h0A && cnt == 2 && le == 1) begin
                        ok = (rsum == xsum);
                        goto_phase(PH_IDLE);
                        if (ok) begin
                            f.hours   = 7'(utc[0] * 10 + utc[1]);
                            f.minutes = 7'(utc[2] * 10 + utc[3]);
                            f.seconds = 7'(utc[4] * 10 + utc[5]);
                            f.lat_deg = lat_deg;
                            f.lat_min = lat_min;
                            f.south   = south;
                            f.lon_deg = lon_deg;
                            f.lon_min = lon_min;
                            f.west    = west;
                            f.speed   = speed;
                            f.track   = track;
                            fix_q.push_back(f);
                        end
                    end else begin
                        goto_phase(PH_IDLE);
                    end
                end
                default: goto_phase(PH_IDLE);
            endcase
        endfunction

        function void report(string what, fix_t exp_f, fix_t act_f);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s exp %p act %p", what, exp_f, act_f);
        endfunction

        function void check_fix(fix_t act_f);
            fix_t e;
            if (fix_q.size() == 0) begin
                report("unexpected result", '0, act_f);
                return;
            end
            e = fix_q.pop_front();
            checked++;
            if (act_f.hours !== e.hours || act_f.minutes !== e.minutes ||
                act_f.seconds !== e.seconds || act_f.lat_deg !== e.lat_deg ||
                act_f.lat_min !== e.lat_min || act_f.south !== e.south ||
                act_f.lon_deg !== e.lon_deg || act_f.lon_min !== e.lon_min ||
                act_f.west !== e.west || act_f.speed !== e.speed || act_f.track !== e.track)
                report("field", e, act_f);
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 0;
    logic        m_valid;
    logic        m_ready = 0;
    fix_t        m_fix;

    fix_scoreboard sb = new();
    bit [7:0]    line_q[$];
    int          send_idle = 0;
    int          recv_idle = 0;
    int          bytes_sent = 0;
    int          sentences = 0;
    int          stall_cycles = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    nmea_rmc_sentence_parser_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_utc_hours(m_fix.hours), .m_utc_minutes(m_fix.minutes),
        .m_utc_seconds(m_fix.seconds), .m_lat_degrees(m_fix.lat_deg),
        .m_lat_minutes_fx(m_fix.lat_min), .m_lat_south(m_fix.south),
        .m_lon_degrees(m_fix.lon_deg), .m_lon_minutes_fx(m_fix.lon_min),
        .m_lon_west(m_fix.west), .m_speed_centi(m_fix.speed), .m_track_centi(m_fix.track)
    );

    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_rx_byte);
            if (m_valid && m_ready) sb.check_fix(m_fix);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= 5000) begin
                $display("watchdog: no transaction for %0d cycles", stall_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_byte(bit [7:0] b);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i]) send_byte(line_q[i]);
        line_q.delete();
        sentences++;
    endtask

    function automatic bit [7:0] hex_char(bit [3:0] v, bit lower);
        if (v < 10) return "0" + v;
        return 8'((lower ? "a" : "A") + v - 10);
    endfunction

    // wraps a body in '$', '*', checksum and CR LF
    function automatic void frame(bit [7:0] body[$], bit bad_sum);
        bit [7:0] x;
        bit       lower;
        x = 0;
        lower = 1'($urandom_range(1));
        foreach (body[i]) x ^= body[i];
        if (bad_sum) x ^= 8'($urandom_range(1, 255));
        line_q.push_back("$");
        foreach (body[i]) line_q.push_back(body[i]);
        line_q.push_back("*");
        line_q.push_back(hex_char(x[7:4], lower));
        line_q.push_back(hex_char(x[3:0], lower));
        line_q.push_back(8'h0D);
        line_q.push_back(8'h0A);
    endfunction

    function automatic void add_text(ref bit [7:0] body[$], input string s);
        for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
    endfunction

    function automatic void add_num(ref bit [7:0] body[$], input int n, input int dot_pct);
        for (int i = 0; i < n; i++)
            body.push_back(($urandom_range(99) < dot_pct) ? "." : 8'("0" + $urandom_range(9)));
    endfunction

    function automatic bit [7:0] rand_letter();
        bit [7:0] c;
        do c = 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
        while (c == "L");
        return c;
    endfunction

    function automatic void build_random();
        bit [7:0] body[$];
        int       mode;
        int       pos;
        mode = $urandom_range(99);
        repeat ($urandom_range(99) < 20 ? $urandom_range(1, 5) : 0)
            line_q.push_back(8'($urandom_range(255)));
        if ($urandom_range(9) == 0) body.push_back(",");
        repeat (5) body.push_back(rand_letter());
        if (body.size() == 5) body.push_back(",");
        add_num(body, ($urandom_range(19) == 0) ? 10 : $urandom_range(6, 9), 0);
        add_text(body, ",A,");
        add_num(body, 2, 0);
        add_num(body, ($urandom_range(19) == 0) ? $urandom_range(0, 1) * 8 + 1
                                                 : $urandom_range(2, 8), 15);
        add_text(body, $urandom_range(1) ? ",S," : ",N,");
        add_num(body, 3, 0);
        add_num(body, $urandom_range(2, 8), 15);
        add_text(body, $urandom_range(1) ? ",W," : ",E,");
        add_num(body, $urandom_range(1, 9), ($urandom_range(3) == 0) ? 0 : 15);
        body.push_back(",");
        add_num(body, $urandom_range(1, 9), ($urandom_range(3) == 0) ? 0 : 15);
        body.push_back(",");
        add_num(body, $urandom_range(6, 10), 0);
        body.push_back(",");
        add_num(body, $urandom_range(1, 4), 20);
        add_text(body, $urandom_range(1) ? ",W" : ",E");
        if (mode < 8) begin
            pos = $urandom_range(body.size() - 1);
            body[pos] = 8'($urandom_range(255));
        end
        frame(body, mode >= 8 && mode < 14);
        if (mode >= 14 && mode < 18) begin
            pos = $urandom_range(line_q.size() - 1);
            while (line_q.size() > pos) void'(line_q.pop_back());
        end else if (mode >= 18 && mode < 21) begin
            line_q[line_q.size() - 3] = "G";
        end
    endfunction

    task automatic send_text(string s, bit bad);
        bit [7:0] body[$];
        add_text(body, s);
        frame(body, bad);
        send_line();
    endtask

    task automatic run_phase(int si, int ri, int nbytes);
        int start_bytes;
        int start_fixes;
        send_idle = si;
        recv_idle = ri;
        start_bytes = bytes_sent;
        start_fixes = sb.checked + sb.fix_q.size();
        while (bytes_sent - start_bytes < nbytes || sb.checked + sb.fix_q.size() - start_fixes < 15)
        begin
            build_random();
            send_line();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_text("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W", 0);
        send_text(",gpRMC,99999999,A,9999999999,S,9999999999,W,999999999,99.99.9,999999,.,E", 0);
        send_text("GPRMC,000000,A,00.,N,000..5,E,.,0,000000,0,E", 0);
        send_text("GPRMC,000000,A,00.0,N,000.0,E,1,1,000000,0,E", 1);
        run_phase(6, 83, 450);
        run_phase(83, 6, 450);
        run_phase(0, 0, 450);
        s_valid <= 0;
        while (sb.fix_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        sb.mismatches += sb.fix_q.size();
        $display("sent %0d bytes in %0d sentences, checked %0d decoded fixes, %0d mismatches",
                 bytes_sent, sentences, sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
